// File: design/xmbr_pkg.sv
// Package for the XMODEM block receiver: sizes, control characters,
// event kinds and status codes shared by the design.
// No dependencies.
package xmbr_pkg;

    // Data bytes in one block and total size of the receive buffer.
    localparam int BLOCK_BYTES  = 128;
    localparam int BUFFER_BYTES = 65536;

    // Width of the accepted byte count (holds BUFFER_BYTES itself).
    localparam int ACC_W = $clog2(BUFFER_BYTES + 1);
    // Width of the index within one block.
    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    localparam logic [ACC_W-1:0] BLOCK_STEP    = ACC_W'(BLOCK_BYTES);
    localparam logic [ACC_W:0]   BUFFER_LIMIT  = (ACC_W + 1)'(BUFFER_BYTES);
    localparam logic [IDX_W-1:0] LAST_INDEX    = IDX_W'(BLOCK_BYTES - 1);

    localparam logic [31:0] NAK_INTERVAL_RESET = 32'd3030101;

    // Control characters of the protocol.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CMP_OK = 8'hFF;

    // Input event kinds.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Transfer status codes.
    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_ERROR     = 2'd3;

endpackage

// File: design/xmodem_block_receiver.sv
// XMODEM receiver with an 8-bit additive checksum, single module.
// Depends on xmbr_pkg for sizes, control characters and status codes.
//
//  Channel   Direction  Handshake           Payload
//  -------   ---------  ------------------  ---------------------------------------
//  input     in         in_valid/in_stall   kind, rx_byte
//  result    out        out_valid/out_stall send_valid, send_code, store_valid,
//                                           store_addr, store_data, status,
//                                           received_size
//  config    in         cfg_write_en        cfg_write_data (nak_interval)
//
// Every accepted event produces exactly one result: it is held in the input
// register, then passes through the protocol logic into the result register.
// One event can be accepted in every cycle while in_stall is low.
// Reset clears the protocol state and loads nak_interval with its default.
// While a result waits under out_stall, the input register still takes one
// more event; in_stall rises only when both registers are occupied.
module xmodem_block_receiver
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_valid,
    output logic [7:0]  send_code,
    output logic        store_valid,
    output logic [15:0] store_addr,
    output logic [7:0]  store_data,
    output logic [1:0]  status,
    output logic [16:0] received_size,

    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data
);

    // Parsing phase of the transfer.
    typedef enum logic [2:0] {
        PH_CTRL,
        PH_NUM,
        PH_CMP,
        PH_DATA,
        PH_SUM,
        PH_DONE,
        PH_CANCEL,
        PH_ERROR
    } phase_t;

    // Configuration register.
    logic [31:0] nak_interval_reg;

    // Input register.
    logic        in_full_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;

    // Protocol state.
    phase_t                     phase_reg, phase_next;
    logic [7:0]                 expected_reg, expected_next;
    logic [7:0]                 got_reg, got_next;
    logic [xmbr_pkg::IDX_W-1:0] index_reg, index_next;
    logic [7:0]                 sum_reg, sum_next;
    logic                       started_reg, started_next;
    logic [xmbr_pkg::ACC_W-1:0] accepted_reg, accepted_next;
    logic [31:0]                ticks_reg, ticks_next;

    // Result register.
    logic        out_full_reg;
    logic        send_valid_reg, send_valid_next;
    logic [7:0]  send_code_reg, send_code_next;
    logic        store_valid_reg, store_valid_next;
    logic [15:0] store_addr_reg, store_addr_next;
    logic [7:0]  store_data_reg, store_data_next;
    logic [1:0]  status_reg, status_next;
    logic [16:0] size_reg, size_next;

    logic out_hold;
    logic step;
    logic [31:0] ticks_inc;
    logic [xmbr_pkg::ACC_W-1:0] addr_sum;

    // The result register is blocked while its content is not taken.
    assign out_hold = out_full_reg && out_stall;
    // The event in the input register moves into the result register.
    assign step     = in_full_reg && !out_hold;
    assign in_stall = in_full_reg && out_hold;

    assign ticks_inc = ticks_reg + 32'd1;
    assign addr_sum  = accepted_reg + xmbr_pkg::ACC_W'(index_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        got_next      = got_reg;
        index_next    = index_reg;
        sum_next      = sum_reg;
        started_next  = started_reg;
        accepted_next = accepted_reg;
        ticks_next    = ticks_reg;

        send_valid_next  = 1'b0;
        send_code_next   = 8'h00;
        store_valid_next = 1'b0;
        store_addr_next  = 16'h0000;
        store_data_next  = 8'h00;

        case (kind_reg)
            xmbr_pkg::KIND_RESTART:
            begin
                phase_next    = PH_CTRL;
                expected_next = 8'd1;
                got_next      = 8'd0;
                index_next    = '0;
                sum_next      = 8'd0;
                started_next  = 1'b0;
                accepted_next = '0;
                ticks_next    = 32'd0;
            end
            xmbr_pkg::KIND_TICK:
            begin
                // Idle ticks only prompt the sender before the first block.
                if (phase_reg == PH_CTRL && !started_reg)
                begin
                    if (ticks_inc >= nak_interval_reg)
                    begin
                        ticks_next      = 32'd0;
                        send_valid_next = 1'b1;
                        send_code_next  = xmbr_pkg::CH_NAK;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            xmbr_pkg::KIND_BYTE:
            begin
                case (phase_reg)
                    PH_CTRL:
                    begin
                        ticks_next = 32'd0;
                        if (byte_reg == xmbr_pkg::CH_CAN)
                        begin
                            phase_next = PH_CANCEL;
                        end
                        else if (byte_reg == xmbr_pkg::CH_EOT)
                        begin
                            send_valid_next = 1'b1;
                            send_code_next  = xmbr_pkg::CH_ACK;
                            phase_next      = PH_DONE;
                        end
                        else if (byte_reg == xmbr_pkg::CH_SOH)
                        begin
                            started_next = 1'b1;
                            if (({1'b0, accepted_reg} + {1'b0, xmbr_pkg::BLOCK_STEP})
                                > xmbr_pkg::BUFFER_LIMIT)
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                phase_next = PH_NUM;
                            end
                        end
                        else if (started_reg)
                        begin
                            // A stray byte after the transfer started is fatal.
                            phase_next = PH_ERROR;
                        end
                    end
                    PH_NUM:
                    begin
                        got_next = byte_reg;
                        if (byte_reg != expected_reg)
                        begin
                            send_valid_next = 1'b1;
                            send_code_next  = xmbr_pkg::CH_NAK;
                            phase_next      = PH_CTRL;
                        end
                        else
                        begin
                            phase_next = PH_CMP;
                        end
                    end
                    PH_CMP:
                    begin
                        if (8'(got_reg + byte_reg) != xmbr_pkg::CMP_OK)
                        begin
                            send_valid_next = 1'b1;
                            send_code_next  = xmbr_pkg::CH_NAK;
                            phase_next      = PH_CTRL;
                        end
                        else
                        begin
                            index_next = '0;
                            sum_next   = 8'd0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        store_valid_next = 1'b1;
                        store_addr_next  = addr_sum[15:0];
                        store_data_next  = byte_reg;
                        sum_next         = sum_reg + byte_reg;
                        index_next       = index_reg + 1'b1;
                        if (index_reg == xmbr_pkg::LAST_INDEX)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        send_valid_next = 1'b1;
                        if (byte_reg == sum_reg)
                        begin
                            send_code_next = xmbr_pkg::CH_ACK;
                            expected_next  = expected_reg + 8'd1;
                            accepted_next  = accepted_reg + xmbr_pkg::BLOCK_STEP;
                        end
                        else
                        begin
                            send_code_next = xmbr_pkg::CH_NAK;
                        end
                        index_next = '0;
                        sum_next   = 8'd0;
                        phase_next = PH_CTRL;
                    end
                    default:
                    begin
                        // Finished transfer: nothing changes until a restart.
                    end
                endcase
            end
            default:
            begin
                // Unused event kind is ignored.
            end
        endcase

        case (phase_next)
            PH_DONE:   status_next = xmbr_pkg::ST_DONE;
            PH_CANCEL: status_next = xmbr_pkg::ST_CANCELLED;
            PH_ERROR:  status_next = xmbr_pkg::ST_ERROR;
            default:   status_next = xmbr_pkg::ST_RUNNING;
        endcase
        size_next = 17'(accepted_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nak_interval_reg <= xmbr_pkg::NAK_INTERVAL_RESET;
            in_full_reg      <= 1'b0;
            out_full_reg     <= 1'b0;
            phase_reg        <= PH_CTRL;
            expected_reg     <= 8'd1;
            got_reg          <= 8'd0;
            index_reg        <= '0;
            sum_reg          <= 8'd0;
            started_reg      <= 1'b0;
            accepted_reg     <= '0;
            ticks_reg        <= 32'd0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                nak_interval_reg <= cfg_write_data;
            end

            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (step)
            begin
                in_full_reg <= 1'b0;
            end

            if (step)
            begin
                out_full_reg <= 1'b1;
                phase_reg    <= phase_next;
                expected_reg <= expected_next;
                got_reg      <= got_next;
                index_reg    <= index_next;
                sum_reg      <= sum_next;
                started_reg  <= started_next;
                accepted_reg <= accepted_next;
                ticks_reg    <= ticks_next;
            end
            else if (!out_stall)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg <= kind;
            byte_reg <= rx_byte;
        end
        if (step)
        begin
            send_valid_reg  <= send_valid_next;
            send_code_reg   <= send_code_next;
            store_valid_reg <= store_valid_next;
            store_addr_reg  <= store_addr_next;
            store_data_reg  <= store_data_next;
            status_reg      <= status_next;
            size_reg        <= size_next;
        end
    end

    assign out_valid     = out_full_reg;
    assign send_valid    = send_valid_reg;
    assign send_code     = send_code_reg;
    assign store_valid   = store_valid_reg;
    assign store_addr    = store_addr_reg;
    assign store_data    = store_data_reg;
    assign status        = status_reg;
    assign received_size = size_reg;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the XMODEM checksum block receiver.
// Depends on xmbr_pkg and xmodem_block_receiver; a built-in predictor
// computes each reply and store, and a monitor compares them in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 60;
    // Hard limit on the run time, well beyond the slowest legal run.
    localparam longint TIMEOUT_NS = 64'd24_000_000;

    // Event kind that the receiver has no meaning for.
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // Phases of the predicted transfer.
    typedef enum logic [2:0] {
        AWAIT_CTRL,
        AWAIT_NUM,
        AWAIT_CMP,
        IN_DATA,
        AWAIT_SUM,
        XFER_DONE,
        XFER_CANCELLED,
        XFER_FAILED
    } xfer_phase_t;

    // Ways in which a generated block can be damaged.
    typedef enum logic [2:0] {
        BLK_GOOD,
        BLK_BAD_SUM,
        BLK_BAD_NUM,
        BLK_BAD_CMP,
        BLK_CUT
    } blk_fault_t;

    // One result transfer, with the fields in port order.
    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_code;
        logic        store_valid;
        logic [15:0] store_addr;
        logic [7:0]  store_data;
        logic [1:0]  status;
        logic [16:0] received_size;
    } reply_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [1:0]  kind           = xmbr_pkg::KIND_TICK;
    logic [7:0]  rx_byte        = 8'h00;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        send_valid;
    logic [7:0]  send_code;
    logic        store_valid;
    logic [15:0] store_addr;
    logic [7:0]  store_data;
    logic [1:0]  status;
    logic [16:0] received_size;
    logic        cfg_write_en   = 1'b0;
    logic [31:0] cfg_write_data = 32'h0;

    xmodem_block_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_valid     (send_valid),
        .send_code      (send_code),
        .store_valid    (store_valid),
        .store_addr     (store_addr),
        .store_data     (store_data),
        .status         (status),
        .received_size  (received_size),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // Predicted receiver state, kept in step with every accepted event.
    int unsigned nak_period  = xmbr_pkg::NAK_INTERVAL_RESET;
    xfer_phase_t rx_phase    = AWAIT_CTRL;
    logic [7:0]  want_block  = 8'd1;
    logic [7:0]  seen_block  = 8'd0;
    int unsigned data_idx    = 0;
    logic [7:0]  data_sum    = 8'd0;
    bit          in_progress = 1'b0;
    int unsigned bytes_kept  = 0;
    int unsigned idle_count  = 0;

    // Replies the receiver still owes, oldest first.
    reply_t      pending_replies[$];
    int          err_count   = 0;
    int          sent_count  = 0;

    // Idling controls shared by the sender, the result-side stall process and the tests.
    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    int          hold_len     = 0;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard limit on the run time in case the receiver hangs.
    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A restart and the power-on reset both return the transfer to its initial state;
    // nak_period is left alone here.
    function automatic void clear_xfer();
        rx_phase    = AWAIT_CTRL;
        want_block  = 8'd1;
        seen_block  = 8'd0;
        data_idx    = 0;
        data_sum    = 8'd0;
        in_progress = 1'b0;
        bytes_kept  = 0;
        idle_count  = 0;
    endfunction

    // Advances the predicted receiver by one event and returns the reply it must produce.
    function automatic reply_t xfer_step(input logic [1:0] k, input logic [7:0] b);
        reply_t r;
        r = '0;
        case (k)
            xmbr_pkg::KIND_RESTART: clear_xfer();
            xmbr_pkg::KIND_TICK: begin
                // Ticks only matter while waiting for the sender to open the first block.
                if (rx_phase == AWAIT_CTRL && !in_progress) begin
                    idle_count = idle_count + 1;
                    if (idle_count >= nak_period) begin
                        idle_count  = 0;
                        r.send_valid = 1'b1;
                        r.send_code  = xmbr_pkg::CH_NAK;
                    end
                end
            end
            xmbr_pkg::KIND_BYTE: begin
                case (rx_phase)
                    AWAIT_CTRL: begin
                        idle_count = 0;
                        if (b == xmbr_pkg::CH_CAN) begin
                            rx_phase = XFER_CANCELLED;
                        end else if (b == xmbr_pkg::CH_EOT) begin
                            r.send_valid = 1'b1;
                            r.send_code  = xmbr_pkg::CH_ACK;
                            rx_phase     = XFER_DONE;
                        end else if (b == xmbr_pkg::CH_SOH) begin
                            in_progress = 1'b1;
                            // A block that would not fit in the buffer is fatal.
                            if (bytes_kept + xmbr_pkg::BLOCK_BYTES > xmbr_pkg::BUFFER_BYTES)
                                rx_phase = XFER_FAILED;
                            else
                                rx_phase = AWAIT_NUM;
                        end else if (in_progress) begin
                            rx_phase = XFER_FAILED;
                        end
                    end
                    AWAIT_NUM: begin
                        seen_block = b;
                        if (b != want_block) begin
                            r.send_valid = 1'b1;
                            r.send_code  = xmbr_pkg::CH_NAK;
                            rx_phase     = AWAIT_CTRL;
                        end else begin
                            rx_phase = AWAIT_CMP;
                        end
                    end
                    AWAIT_CMP: begin
                        // The number and its complement must add up to 0xFF modulo 256.
                        if (8'(seen_block + b) != xmbr_pkg::CMP_OK) begin
                            r.send_valid = 1'b1;
                            r.send_code  = xmbr_pkg::CH_NAK;
                            rx_phase     = AWAIT_CTRL;
                        end else begin
                            data_idx = 0;
                            data_sum = 8'd0;
                            rx_phase = IN_DATA;
                        end
                    end
                    IN_DATA: begin
                        r.store_valid = 1'b1;
                        r.store_addr  = 16'(bytes_kept + data_idx);
                        r.store_data  = b;
                        data_sum      = data_sum + b;
                        data_idx      = data_idx + 1;
                        if (data_idx >= xmbr_pkg::BLOCK_BYTES)
                            rx_phase = AWAIT_SUM;
                    end
                    AWAIT_SUM: begin
                        r.send_valid = 1'b1;
                        if (b == data_sum) begin
                            r.send_code = xmbr_pkg::CH_ACK;
                            want_block  = want_block + 8'd1;
                            bytes_kept  = bytes_kept + xmbr_pkg::BLOCK_BYTES;
                        end else begin
                            r.send_code = xmbr_pkg::CH_NAK;
                        end
                        data_idx = 0;
                        data_sum = 8'd0;
                        rx_phase = AWAIT_CTRL;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        case (rx_phase)
            XFER_DONE:      r.status = xmbr_pkg::ST_DONE;
            XFER_CANCELLED: r.status = xmbr_pkg::ST_CANCELLED;
            XFER_FAILED:    r.status = xmbr_pkg::ST_ERROR;
            default:        r.status = xmbr_pkg::ST_RUNNING;
        endcase
        r.received_size = 17'(bytes_kept);
        return r;
    endfunction

    // Offers one event and waits for its transfer; the expected reply is recorded on
    // acceptance.
    // in_valid stays high between back-to-back events, so it is never lowered and raised
    // in the same step.
    task automatic send_event(input logic [1:0] k, input logic [7:0] b);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        // in_stall is read right after the edge, so this is its value at that edge.
        do @(posedge clk); while (in_stall);
        pending_replies.push_back(xfer_step(k, b));
        sent_count++;
    endtask

    // Stops offering events and waits until every expected reply has been checked,
    // then lets the pipeline settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes nak_interval. Callers make sure the receiver is idle first.
    task automatic write_nak(input logic [31:0] v);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        nak_period = v;
        @(posedge clk);
    endtask

    // Sends one block that starts with SOH and carries random data, damaged as asked.
    // After a bad header, stray_tail keeps sending the rest of the block, which the
    // receiver must take as stray bytes.
    task automatic send_block(input blk_fault_t fault, input bit stray_tail);
        logic [7:0] num;
        logic [7:0] sum;
        logic [7:0] d;
        int         n_data;
        num    = want_block;
        sum    = 8'd0;
        n_data = xmbr_pkg::BLOCK_BYTES;
        if (fault == BLK_BAD_NUM)
            num = want_block + 8'($urandom_range(1, 255));
        if (fault == BLK_CUT)
            n_data = $urandom_range(1, xmbr_pkg::BLOCK_BYTES - 1);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_SOH);
        send_event(xmbr_pkg::KIND_BYTE, num);
        if (fault == BLK_BAD_NUM && !stray_tail)
            return;
        if (fault == BLK_BAD_CMP)
            send_event(xmbr_pkg::KIND_BYTE, ~num ^ 8'($urandom_range(1, 255)));
        else
            send_event(xmbr_pkg::KIND_BYTE, ~num);
        if ((fault == BLK_BAD_NUM || fault == BLK_BAD_CMP) && !stray_tail)
            return;
        // After a header fault only three data bytes are sent, as the first stray byte already ends
        // the transfer.
        if (fault == BLK_BAD_NUM || fault == BLK_BAD_CMP)
            n_data = 3;
        for (int i = 0; i < n_data; i++) begin
            d   = 8'($urandom);
            sum = sum + d;
            send_event(xmbr_pkg::KIND_BYTE, d);
        end
        if (fault == BLK_GOOD)
            send_event(xmbr_pkg::KIND_BYTE, sum);
        else if (fault == BLK_BAD_SUM)
            send_event(xmbr_pkg::KIND_BYTE, sum + 8'($urandom_range(1, 255)));
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            err_count++;
        end
    endtask

    // Result monitor: every result transfer is matched against the oldest expected reply.
    always @(posedge clk) begin
        reply_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t ns: result with no event pending, send 0x%0h store %0b@0x%0h",
                         $time, send_code, store_valid, store_addr);
                err_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("send_valid", 32'(want.send_valid), 32'(send_valid));
                check_field("send_code", 32'(want.send_code), 32'(send_code));
                check_field("store_valid", 32'(want.store_valid), 32'(store_valid));
                check_field("store_addr", 32'(want.store_addr), 32'(store_addr));
                check_field("store_data", 32'(want.store_data), 32'(store_data));
                check_field("status", 32'(want.status), 32'(status));
                check_field("received_size", 32'(want.received_size),
                            32'(received_size));
            end
        end
    end

    // Result-side stall. A long hold requested by a test is counted here; otherwise
    // random stall bursts come while sink idling is enabled.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                out_stall <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // NAK prompts before the first block at several interval settings, including the
    // reset value, the zero interval and the largest interval.
    task automatic test_nak_prompts();
        send_event(xmbr_pkg::KIND_TICK, 8'hAA);
        send_event(KIND_UNKNOWN, 8'h55);
        drain_results();
        write_nak(32'd1);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'hFF);
        drain_results();
        write_nak(32'd0);
        send_event(xmbr_pkg::KIND_TICK, 8'h0F);
        drain_results();
        write_nak(32'd3);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        // A stray byte before the first block is ignored but restarts the tick count.
        send_event(xmbr_pkg::KIND_BYTE, 8'hFF);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        drain_results();
        write_nak(32'hFFFF_FFFF);
        send_event(xmbr_pkg::KIND_TICK, 8'hF0);
        drain_results();
    endtask

    // EOT ends the transfer as done, CAN as cancelled; a finished transfer ignores bytes
    // and ticks until a restart.
    task automatic test_control_bytes();
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_EOT);
        send_event(xmbr_pkg::KIND_BYTE, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_RESTART, 8'hFF);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_CAN);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_SOH);
        send_event(xmbr_pkg::KIND_RESTART, 8'h00);
        drain_results();
    endtask

    // A wrong block number and a wrong complement each get a NAK at once; a stray byte
    // after the first SOH is a protocol error.
    task automatic test_header_faults();
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_SOH);
        send_event(xmbr_pkg::KIND_BYTE, 8'h02);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_SOH);
        send_event(xmbr_pkg::KIND_BYTE, 8'h01);
        send_event(xmbr_pkg::KIND_BYTE, 8'h00);
        send_event(xmbr_pkg::KIND_BYTE, 8'h7E);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_RESTART, 8'h00);
        drain_results();
    endtask

    // Random traffic, mostly well-formed blocks with random data, mixed with damaged
    // blocks, ticks, stray bytes, unknown kinds and restarts. Both sides idle at random.
    task automatic test_random_transfers();
        int  first;
        int  pick;
        bit  reconfigured;
        reconfigured = 1'b0;
        write_nak($urandom_range(1, 5));
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        first = sent_count;
        while (sent_count - first < RANDOM_ITEMS) begin
            if (!reconfigured && sent_count - first > RANDOM_ITEMS / 2) begin
                drain_results();
                write_nak($urandom_range(1, 3));
                reconfigured = 1'b1;
            end
            if (rx_phase >= XFER_DONE) begin
                // A finished transfer mostly gets restarted; the rest checks that it holds.
                if ($urandom_range(0, 9) < 7)
                    send_event(xmbr_pkg::KIND_RESTART, 8'($urandom));
                else
                    send_event(2'($urandom), 8'($urandom));
            end else if (rx_phase != AWAIT_CTRL) begin
                // Left inside a block by a cut block or a random SOH: keep feeding it bytes.
                send_event(xmbr_pkg::KIND_BYTE, 8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        send_block(BLK_GOOD, 1'b0);
                    else if (pick < 75)
                        send_block(BLK_BAD_SUM, 1'b0);
                    else if (pick < 84)
                        send_block(BLK_BAD_NUM, 1'($urandom));
                    else if (pick < 93)
                        send_block(BLK_BAD_CMP, 1'($urandom));
                    else
                        send_block(BLK_CUT, 1'b0);
                end else if (pick < 65) begin
                    send_event(xmbr_pkg::KIND_TICK, 8'($urandom));
                end else if (pick < 78) begin
                    case ($urandom_range(0, 2))
                        0:       send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_EOT);
                        1:       send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_CAN);
                        default: send_event(xmbr_pkg::KIND_BYTE, 8'($urandom));
                    endcase
                end else if (pick < 86) begin
                    send_event(KIND_UNKNOWN, 8'($urandom));
                end else begin
                    send_event(xmbr_pkg::KIND_RESTART, 8'($urandom));
                end
            end
        end
        drain_results();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
    endtask

    // The result side is held for a long stretch while a whole block is offered back
    // to back, so both internal registers fill and in_stall must rise. The sender then
    // waits until all replies are out before it ends the transfer.
    task automatic test_backpressure();
        send_event(xmbr_pkg::KIND_RESTART, 8'h00);
        hold_len = HOLD_CYCLES;
        send_block(BLK_GOOD, 1'b0);
        drain_results();
        sink_idle_on = 1'b1;
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_EOT);
        drain_results();
        sink_idle_on = 1'b0;
    endtask

    // A short sequence back to back: a wrong block number after the first SOH, then EOT
    // ends the transfer, and a restart returns to prompting.
    // This is the last part of the run, so neither side idles here.
    task automatic test_closing_sequence();
        send_event(xmbr_pkg::KIND_RESTART, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_SOH);
        send_event(xmbr_pkg::KIND_BYTE, 8'h05);
        send_event(xmbr_pkg::KIND_BYTE, xmbr_pkg::CH_EOT);
        send_event(xmbr_pkg::KIND_RESTART, 8'h00);
        send_event(xmbr_pkg::KIND_TICK, 8'h00);
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_nak_prompts();
        test_control_bytes();
        test_header_faults();
        test_random_transfers();
        test_backpressure();
        test_closing_sequence();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
